// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define TPC_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked on every edge, reset included.
`define TPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tpc_pkg.sv =====
// Types and constants shared by the test pattern checker modules.
`timescale 1ns / 1ps

package tpc_pkg;

  // Item kinds on the request channel.
  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_BYTE   = 1'b1;

  // Pattern generator constants.
  localparam logic [31:0] SALT_DOWN  = 32'hA5A55A5A;
  localparam logic [31:0] SALT_UP    = 32'h5A5AA5A5;
  localparam logic [31:0] SEED_MULT  = 32'h045D9F3B;
  localparam logic [31:0] HASH_MULT  = 32'h85EBCA6B;
  localparam int unsigned HashShift1 = 13;
  localparam int unsigned HashShift2 = 16;
  // Only the low 24 bits of the product reach the expected byte.
  localparam int unsigned HashW      = 24;

  // Jitter is unsigned Q44.4.
  localparam int unsigned JitW       = 48;
  localparam int unsigned JitFrac    = 4;
  localparam int unsigned JitIntW    = JitW - JitFrac;

  // Queue between the front and back parts.
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);

  typedef struct packed {
    logic        req_type;
    logic [63:0] seq_number;
    logic [31:0] stream_ident;
    logic        download_dir;
    logic        warmup_frame;
    logic [15:0] frame_length;
    logic [63:0] send_time_us;
    logic [63:0] arrival_time_us;
    logic [7:0]  payload_byte;
  } tpc_req_t;

  typedef struct packed {
    logic        pattern_ok;
    logic        was_warmup;
    logic [63:0] lost_count;
    logic [63:0] duplicate_count;
    logic [63:0] reorder_count;
    logic [63:0] valid_count;
    logic [63:0] error_count;
    logic [63:0] byte_count;
    logic [63:0] packet_count;
    logic [47:0] jitter_q4;
  } tpc_rsp_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic             is_hdr;
    logic             warm;
    logic             no_send;
    logic             last;     // header of an empty frame, or final payload byte
    logic [15:0]      len;
    logic [63:0]      seq;
    logic [63:0]      transit;
    logic [HashW-1:0] hv;       // pattern state before the multiply
    logic [7:0]       pbyte;
  } tpc_entry_t;

endpackage

// ===== hw/rtl/tpc_front.sv =====
// Front part: accepts items, tracks the open frame and classifies each item.
`timescale 1ns / 1ps

module tpc_front import tpc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 65535
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  tpc_req_t   req_data,
  input  logic       q_full,
  output logic       push,
  output tpc_entry_t push_entry
);

  localparam int unsigned LenCap = (MAX_PAYLOAD < 65535) ? MAX_PAYLOAD : 65535;

  logic [31:0] seed;
  logic [15:0] byte_index;
  logic [15:0] frame_len;

  logic        accept;
  logic        is_hdr;
  logic        open;
  logic [15:0] len_clamped;
  logic [31:0] seed_next;
  logic [31:0] hash_sum;
  logic [31:0] hash_mix;
  logic [31:0] stream_mult;
  logic [63:0] transit;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;
  assign is_hdr    = (req_data.req_type == REQ_HEADER);
  assign open      = (byte_index < frame_len);

  always_comb begin
    if (32'(req_data.frame_length) > LenCap) begin
      len_clamped = 16'(LenCap);
    end else begin
      len_clamped = req_data.frame_length;
    end
    stream_mult = req_data.stream_ident * SEED_MULT;
    seed_next   = req_data.seq_number[31:0] ^ req_data.seq_number[63:32] ^ stream_mult ^
                  (req_data.download_dir ? SALT_DOWN : SALT_UP);
    hash_sum    = seed + 32'(byte_index);
    hash_mix    = hash_sum ^ (hash_sum >> HashShift1);
    if (req_data.arrival_time_us > req_data.send_time_us) begin
      transit = req_data.arrival_time_us - req_data.send_time_us;
    end else begin
      transit = 64'd0;
    end
  end

  // Stray payload bytes outside a frame are dropped here.
  assign push = accept && (is_hdr || open);

  always_comb begin
    push_entry.is_hdr  = is_hdr;
    push_entry.warm    = req_data.warmup_frame;
    push_entry.no_send = (req_data.send_time_us == 64'd0);
    push_entry.seq     = req_data.seq_number;
    push_entry.transit = transit;
    push_entry.hv      = hash_mix[HashW-1:0];
    push_entry.pbyte   = req_data.payload_byte;
    if (is_hdr) begin
      push_entry.len  = len_clamped;
      push_entry.last = (len_clamped == 16'd0);
    end else begin
      push_entry.len  = frame_len;
      push_entry.last = ((byte_index + 16'd1) == frame_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= 32'd0;
      byte_index <= 16'd0;
      frame_len  <= 16'd0;
    end else if (accept) begin
      if (is_hdr) begin
        seed       <= seed_next;
        frame_len  <= len_clamped;
        byte_index <= 16'd0;
      end else if (open) begin
        byte_index <= byte_index + 16'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/tpc_queue.sv =====
// Short register queue that separates the front part from the back part.
`timescale 1ns / 1ps

module tpc_queue import tpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tpc_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output tpc_entry_t head
);

  tpc_entry_t       entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;

  assign full       = (count == (QPtrW + 1)'(QDepth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tpc_back.sv =====
// Back part: sequence and jitter tracking, pattern compare, counters and result.
`timescale 1ns / 1ps

module tpc_back import tpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  tpc_entry_t head,
  output logic       pop,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output tpc_rsp_t   rsp_data
);

  typedef struct packed {
    logic             is_hdr;
    logic             warm;
    logic             last;
    logic [15:0]      len;
    logic             lost_inc;
    logic             dup_inc;
    logic             reorder_inc;
    logic [63:0]      lost_delta;
    logic             jit_do;
    logic [JitW-1:0]  jit_d;
    logic [HashW-1:0] prod;
    logic [7:0]       pbyte;
  } tpc_stage_t;

  // First stage state.
  logic [63:0] expected_seq;
  logic [63:0] last_transit;
  logic        b1_valid;
  tpc_stage_t  b1;

  // Second stage state.
  logic [63:0]     lost_acc;
  logic [63:0]     dup_acc;
  logic [63:0]     reorder_acc;
  logic [63:0]     valid_acc;
  logic [63:0]     err_acc;
  logic [63:0]     bytes_acc;
  logic [63:0]     packets_acc;
  logic [JitW-1:0] jitter_acc;
  logic            running_match;
  logic            warmup_reg;

  logic       adv;
  logic       fire;
  logic       h_stat;
  logic       seq_ge;
  logic       seq_eq;
  logic [63:0] diff;
  tpc_stage_t b1_next;

  // The whole back pipeline moves when the result register can take a value.
  assign adv  = !rsp_valid || rsp_ready;
  assign pop  = head_valid && adv;
  assign fire = b1_valid && adv;

  assign h_stat = head.is_hdr && !head.warm;
  assign seq_ge = (head.seq >= expected_seq);
  assign seq_eq = (head.seq == expected_seq);

  always_comb begin
    if (head.transit > last_transit) begin
      diff = head.transit - last_transit;
    end else begin
      diff = last_transit - head.transit;
    end
    b1_next.is_hdr      = head.is_hdr;
    b1_next.warm        = head.warm;
    b1_next.last        = head.last;
    b1_next.len         = head.len;
    b1_next.lost_inc    = h_stat && seq_ge && !seq_eq;
    b1_next.dup_inc     = h_stat && !seq_ge;
    b1_next.reorder_inc = h_stat && !seq_eq;
    b1_next.lost_delta  = head.seq - expected_seq;
    b1_next.jit_do      = h_stat && !head.no_send && (last_transit != 64'd0);
    // A difference too large for Q44.4 saturates to all ones.
    if (diff[63:JitIntW] != '0) begin
      b1_next.jit_d = '1;
    end else begin
      b1_next.jit_d = {diff[JitIntW-1:0], {JitFrac{1'b0}}};
    end
    b1_next.prod  = head.hv * HASH_MULT[HashW-1:0];
    b1_next.pbyte = head.pbyte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= 64'd0;
      last_transit <= 64'd0;
      b1_valid     <= 1'b0;
    end else if (adv) begin
      b1_valid <= pop;
      if (pop && h_stat) begin
        // Equal and ahead both move the expectation past this frame.
        if (seq_ge) begin
          expected_seq <= head.seq + 64'd1;
        end
        if (!head.no_send) begin
          last_transit <= head.transit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1 <= b1_next;
    end
  end

  // Second stage: accumulate and form the result.
  logic [63:0]           lost_n;
  logic [63:0]           dup_n;
  logic [63:0]           reorder_n;
  logic [63:0]           valid_n;
  logic [63:0]           err_n;
  logic [63:0]           bytes_n;
  logic [63:0]           packets_n;
  logic [JitW-1:0]       jitter_n;
  logic [JitW+JitFrac-1:0] jit_sum;
  logic                  byte_match;
  logic                  match_n;
  logic                  warm_frame;
  logic                  stat;
  logic [7:0]            expect_byte;

  always_comb begin
    lost_n    = b1.lost_inc ? (lost_acc + b1.lost_delta) : lost_acc;
    dup_n     = b1.dup_inc ? (dup_acc + 64'd1) : dup_acc;
    reorder_n = b1.reorder_inc ? (reorder_acc + 64'd1) : reorder_acc;
    // J + floor((D - J) / 16) equals floor((15 J + D) / 16).
    jit_sum   = {jitter_acc, {JitFrac{1'b0}}} - (JitW + JitFrac)'(jitter_acc) +
                (JitW + JitFrac)'(b1.jit_d);
    jitter_n  = b1.jit_do ? jit_sum[JitW+JitFrac-1:JitFrac] : jitter_acc;

    expect_byte = b1.prod[7:0] ^ b1.prod[HashShift2+7:HashShift2];
    byte_match  = (expect_byte == b1.pbyte);
    match_n     = b1.is_hdr ? 1'b1 : (running_match && byte_match);
    warm_frame  = b1.is_hdr ? b1.warm : warmup_reg;
    stat        = b1.last && !warm_frame;

    bytes_n   = stat ? (bytes_acc + 64'(b1.len)) : bytes_acc;
    packets_n = stat ? (packets_acc + 64'd1) : packets_acc;
    valid_n   = (stat && match_n) ? (valid_acc + 64'd1) : valid_acc;
    err_n     = (stat && !match_n) ? (err_acc + 64'd1) : err_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_acc      <= 64'd0;
      dup_acc       <= 64'd0;
      reorder_acc   <= 64'd0;
      valid_acc     <= 64'd0;
      err_acc       <= 64'd0;
      bytes_acc     <= 64'd0;
      packets_acc   <= 64'd0;
      jitter_acc    <= '0;
      running_match <= 1'b1;
      warmup_reg    <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (fire) begin
        lost_acc      <= lost_n;
        dup_acc       <= dup_n;
        reorder_acc   <= reorder_n;
        valid_acc     <= valid_n;
        err_acc       <= err_n;
        bytes_acc     <= bytes_n;
        packets_acc   <= packets_n;
        jitter_acc    <= jitter_n;
        running_match <= b1.last ? 1'b1 : match_n;
        if (b1.is_hdr) begin
          warmup_reg <= b1.warm;
        end
      end
      if (fire && b1.last) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && b1.last) begin
      rsp_data.pattern_ok      <= match_n;
      rsp_data.was_warmup      <= warm_frame;
      rsp_data.lost_count      <= lost_n;
      rsp_data.duplicate_count <= dup_n;
      rsp_data.reorder_count   <= reorder_n;
      rsp_data.valid_count     <= valid_n;
      rsp_data.error_count     <= err_n;
      rsp_data.byte_count      <= bytes_n;
      rsp_data.packet_count    <= packets_n;
      rsp_data.jitter_q4       <= jitter_n;
    end
  end

endmodule

// ===== hw/rtl/test_pattern_checker_top.sv =====
// Receive-side test pattern checker: top level.
//
// The req channel takes one item per transfer: a frame header (sequence,
// stream id, direction, warmup flag, length, send and arrival times) or one
// payload byte. The rsp channel gives one result per completed frame with the
// pattern verdict, the warmup flag and all running statistics.
// Throughput is one item per cycle while the queue is not full. A result is
// valid once the final payload byte (or the header of an empty frame) has
// passed through the item queue and the multiply stage, then through the
// accumulators into the result register.
// Payload bytes outside a frame are dropped and give no result.
// If the receiver stalls, the result register holds, the back stages stop and
// the four-entry queue keeps taking items until it is full; req_ready then
// drops. Reset clears all counters, the sequence tracking and the jitter
// estimate and empties the queue; req_ready is high as soon as reset ends.
`timescale 1ns / 1ps

module test_pattern_checker_top import tpc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 65535
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tpc_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tpc_rsp_t rsp_data
);

  logic       q_full;
  logic       push;
  tpc_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  tpc_entry_t head;

  tpc_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  tpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  tpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== hw/rtl/tpc_checker.sv =====
// Port-level assertions for the test pattern checker and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpc_checker import tpc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input tpc_req_t req_data,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input tpc_rsp_t rsp_data
);

  // A stalled result keeps its contents.
  `TPC_ASSERT_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

  // Every counted frame is either valid or in error.
  `TPC_ASSERT_RST(a_count_split, clk, rst, rsp_valid |-> (rsp_data.valid_count + rsp_data.error_count) == rsp_data.packet_count, "valid plus error differs from packets")

  // No result is offered right after reset.
  `TPC_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !rsp_valid, "result valid after reset")

  // A taken warmup result still has valid plus error equal to packets.
  `TPC_ASSERT_RST(a_warm_flag, clk, rst, rsp_valid && rsp_ready && rsp_data.was_warmup |-> rsp_data.valid_count + rsp_data.error_count == rsp_data.packet_count, "warmup result inconsistent")

endmodule

bind test_pattern_checker_top tpc_checker u_tpc_checker (.*);
